/* design/track_box_gap_filler_macros.svh */
// ----------------------------------------------------------------------------
// Track box gap filler assertion macros
// Short forms for clocked implications on the block's ports.
// ----------------------------------------------------------------------------
`ifndef TRACK_BOX_GAP_FILLER_MACROS_SVH
`define TRACK_BOX_GAP_FILLER_MACROS_SVH

// Same-cycle implication.
`define TBGF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbgf check failed");

// Next-cycle implication.
`define TBGF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbgf check failed");

`endif

/* design/tbgf_pkg.sv */
// ----------------------------------------------------------------------------
// Track box gap filler package
// Widths, the stored entry record and the center saturation helper.
// ----------------------------------------------------------------------------
package tbgf_pkg;

  localparam int MAX_TRACK = 64;
  localparam int IDX_W     = $clog2(MAX_TRACK);
  localparam int CNT_W     = $clog2(MAX_TRACK + 1);

  localparam int C_W    = 20;  // center and shift
  localparam int S_W    = 16;  // width, height, confidence
  localparam int L_W    = 10;  // class label
  localparam int DIFF_W = C_W + 1;
  localparam int PROD_W = C_W + DIFF_W;
  localparam int SUM_W  = C_W + IDX_W + 1;
  localparam int EXT_W  = PROD_W + 1;

  localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'((1 << (C_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SAT_MIN = -SAT_MAX - EXT_W'(1);

  typedef struct packed {
    logic                  valid;
    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] cy;
    logic [S_W-1:0]        w;
    logic [S_W-1:0]        h;
    logic [S_W-1:0]        conf;
    logic [L_W-1:0]        label;
    logic signed [C_W-1:0] sx;
    logic signed [C_W-1:0] sy;
  } entry_t;

  function automatic logic signed [C_W-1:0] sat_sum(input logic signed [C_W-1:0] a,
                                                    input logic signed [PROD_W-1:0] b);
    logic signed [EXT_W-1:0] s;
    s = EXT_W'(a) + EXT_W'(b);
    if (s > SAT_MAX) begin
      return C_W'(SAT_MAX);
    end else if (s < SAT_MIN) begin
      return C_W'(SAT_MIN);
    end
    return C_W'(s);
  endfunction

endpackage

/* design/tbgf_div.sv */
// ----------------------------------------------------------------------------
// Track box gap filler divider
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tbgf_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [tbgf_pkg::PROD_W-1:0]    dividend_i,
  input  logic signed [tbgf_pkg::SUM_W-1:0]     divisor_i,
  output logic                                  done_o,
  output logic signed [tbgf_pkg::PROD_W-1:0]    quot_o
);
  import tbgf_pkg::*;

  localparam int DC_W = $clog2(PROD_W + 1);

  logic              run_q, done_q, neg_q;
  logic [DC_W-1:0]   cnt_q;
  logic [PROD_W-1:0] quo_q;
  logic [SUM_W:0]    rem_q;
  logic [SUM_W-1:0]  dvs_q;
  logic [SUM_W:0]    shifted;
  logic [SUM_W:0]    trial;

  assign shifted = {rem_q[SUM_W-1:0], quo_q[PROD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DC_W'(PROD_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - DC_W'(1);
        if (cnt_q == DC_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[PROD_W-1] ? PROD_W'(-dividend_i) : PROD_W'(dividend_i);
      dvs_q <= divisor_i[SUM_W-1] ? SUM_W'(-divisor_i) : SUM_W'(divisor_i);
      neg_q <= dividend_i[PROD_W-1] ^ divisor_i[SUM_W-1];
      rem_q <= '0;
    end else if (run_q) begin
      // keep the trial difference when it does not borrow
      if (!trial[SUM_W]) begin
        rem_q <= trial;
        quo_q <= {quo_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[PROD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

/* design/track_box_gap_filler.sv */
// ----------------------------------------------------------------------------
// Track box gap filler
// Stores one track, then emits its stored entries with missing boxes filled in.
// ----------------------------------------------------------------------------
// Usage: drive one track entry with start; it is taken at an edge where start
// is high and busy is low. Entries without last are stored, up to MAX_TRACK
// in a track, and give no result. The entry with last starts the fill; busy
// stays high until the last result of the track is out. Results appear one
// per entry on the out_* ports, each for a single cycle marked by out_valid_o;
// out_last_o marks the final one. A track without any box gives a single
// result with track_dropped_o set. The receiver cannot stall the block.
// After last, a backward pass fills the entries before the first box, a
// forward output pass emits every entry, each gap is scanned to sum its
// shifts, and each interpolated entry waits on the bit-serial divider
// (one quotient bit a cycle). Everything runs off a single-port-write,
// single-read track memory with a registered read.
// Reset empties the track; the memory needs no clearing.
// ----------------------------------------------------------------------------
module track_box_gap_filler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                has_box_i,
  input  logic signed [tbgf_pkg::C_W-1:0]     center_x_i,
  input  logic signed [tbgf_pkg::C_W-1:0]     center_y_i,
  input  logic [tbgf_pkg::S_W-1:0]            box_width_i,
  input  logic [tbgf_pkg::S_W-1:0]            box_height_i,
  input  logic [tbgf_pkg::S_W-1:0]            confidence_i,
  input  logic [tbgf_pkg::L_W-1:0]            class_label_i,
  input  logic signed [tbgf_pkg::C_W-1:0]     shift_x_i,
  input  logic signed [tbgf_pkg::C_W-1:0]     shift_y_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  output logic signed [tbgf_pkg::C_W-1:0]     out_center_x_o,
  output logic signed [tbgf_pkg::C_W-1:0]     out_center_y_o,
  output logic [tbgf_pkg::S_W-1:0]            out_width_o,
  output logic [tbgf_pkg::S_W-1:0]            out_height_o,
  output logic [tbgf_pkg::S_W-1:0]            out_confidence_o,
  output logic [tbgf_pkg::L_W-1:0]            out_label_o,
  output logic                                was_filled_o,
  output logic                                track_dropped_o,
  output logic                                out_last_o
);
  import tbgf_pkg::*;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_DROP  = 4'd1;
  localparam logic [3:0] ST_L0    = 4'd2;
  localparam logic [3:0] ST_L1    = 4'd3;
  localparam logic [3:0] ST_L2    = 4'd4;
  localparam logic [3:0] ST_F0    = 4'd5;
  localparam logic [3:0] ST_F1    = 4'd6;
  localparam logic [3:0] ST_S1    = 4'd7;
  localparam logic [3:0] ST_MUL   = 4'd8;
  localparam logic [3:0] ST_DST   = 4'd9;
  localparam logic [3:0] ST_DWAIT = 4'd10;

  // track memory
  entry_t            mem_q [MAX_TRACK];
  entry_t            rd_q;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, n_q, n_d;
  logic [IDX_W-1:0] first_q, first_d, lastb_q, lastb_d;
  logic [IDX_W-1:0] idx_q, idx_d, sp_q, sp_d;
  logic             any_q, any_d;
  entry_t           cur_q, cur_d, prev_q, prev_d;
  logic signed [SUM_W-1:0]  tx_q, tx_d, ty_q, ty_d;
  logic signed [DIFF_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [C_W-1:0]    sxq_q, sxq_d, syq_q, syq_d;
  logic signed [PROD_W-1:0] px_q, px_d, py_q, py_d;

  logic                  ov_q, ov_d;
  logic signed [C_W-1:0] ocx_q, ocx_d, ocy_q, ocy_d;
  logic [S_W-1:0]        ow_q, ow_d, oh_q, oh_d, oc_q, oc_d;
  logic [L_W-1:0]        ol_q, ol_d;
  logic                  ofill_q, ofill_d, odrop_q, odrop_d, olast_q, olast_d;

  logic                     div_start, divx_done, divy_done;
  logic signed [PROD_W-1:0] qx, qy;

  entry_t           in_rec, d, lead;
  logic             wr_ok, any_n, is_last;
  logic [IDX_W-1:0] fst;
  logic signed [C_W-1:0] ncx, ncy;

  tbgf_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(px_q), .divisor_i(tx_q),
    .done_o(divx_done), .quot_o(qx)
  );
  tbgf_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(py_q), .divisor_i(ty_q),
    .done_o(divy_done), .quot_o(qy)
  );

  always_comb begin
    in_rec = '{valid: has_box_i, cx: center_x_i, cy: center_y_i, w: box_width_i,
               h: box_height_i, conf: confidence_i, label: class_label_i,
               sx: shift_x_i, sy: shift_y_i};
    d       = rd_q;
    wr_ok   = cnt_q < CNT_W'(MAX_TRACK);
    is_last = ({1'b0, idx_q} == (n_q - CNT_W'(1)));
    any_n   = any_q | (wr_ok & has_box_i);
    fst     = any_q ? first_q : cnt_q[IDX_W-1:0];

    lead       = d;
    lead.cx    = sat_sum(cur_q.cx, -PROD_W'(cur_q.sx));
    lead.cy    = sat_sum(cur_q.cy, -PROD_W'(cur_q.sy));
    lead.w     = cur_q.w;
    lead.h     = cur_q.h;
    lead.conf  = cur_q.conf;
    lead.label = cur_q.label;
    ncx = '0;
    ncy = '0;

    state_d = state_q;
    cnt_d = cnt_q;  n_d = n_q;  first_d = first_q;  lastb_d = lastb_q;
    idx_d = idx_q;  sp_d = sp_q;  any_d = any_q;
    cur_d = cur_q;  prev_d = prev_q;
    tx_d = tx_q;  ty_d = ty_q;  dx_d = dx_q;  dy_d = dy_q;
    sxq_d = sxq_q;  syq_d = syq_q;  px_d = px_q;  py_d = py_q;
    ov_d = 1'b0;
    ocx_d = ocx_q;  ocy_d = ocy_q;  ow_d = ow_q;  oh_d = oh_q;  oc_d = oc_q;
    ol_d = ol_q;  ofill_d = ofill_q;  odrop_d = odrop_q;  olast_d = olast_q;
    we = 1'b0;  waddr = cnt_q[IDX_W-1:0];  wdata = in_rec;
    raddr = idx_q;
    div_start = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (start) begin
          we = wr_ok;
          if (wr_ok) begin
            cnt_d = cnt_q + CNT_W'(1);
            if (has_box_i) begin
              if (!any_q) begin
                first_d = cnt_q[IDX_W-1:0];
              end
              lastb_d = cnt_q[IDX_W-1:0];
              any_d   = 1'b1;
            end
          end
          if (last_i) begin
            n_d   = wr_ok ? cnt_q + CNT_W'(1) : cnt_q;
            cnt_d = '0;
            idx_d = '0;
            if (!any_n) begin
              state_d = ST_DROP;
            end else if (fst == '0) begin
              state_d = ST_F0;
            end else begin
              state_d = ST_L0;
            end
          end
        end
      end
      ST_DROP: begin
        ov_d = 1'b1;
        ocx_d = '0;  ocy_d = '0;  ow_d = '0;  oh_d = '0;  oc_d = '0;  ol_d = '0;
        ofill_d = 1'b0;  odrop_d = 1'b1;  olast_d = 1'b1;
        any_d = 1'b0;
        state_d = ST_LOAD;
      end
      ST_L0: begin
        raddr   = first_q;
        state_d = ST_L1;
      end
      ST_L1: begin
        cur_d   = d;
        idx_d   = first_q - IDX_W'(1);
        raddr   = first_q - IDX_W'(1);
        state_d = ST_L2;
      end
      ST_L2: begin
        // step back from the entry after this one
        we    = 1'b1;
        waddr = idx_q;
        wdata = lead;
        cur_d = lead;
        if (idx_q == '0) begin
          state_d = ST_F0;
        end else begin
          idx_d = idx_q - IDX_W'(1);
          raddr = idx_q - IDX_W'(1);
        end
      end
      ST_F0: begin
        raddr   = idx_q;
        state_d = ST_F1;
      end
      ST_F1: begin
        ov_d = 1'b1;
        ocx_d = d.cx;  ocy_d = d.cy;  ow_d = d.w;  oh_d = d.h;
        oc_d = d.conf;  ol_d = d.label;
        ofill_d = ~d.valid;  odrop_d = 1'b0;  olast_d = is_last;
        idx_d = idx_q + IDX_W'(1);
        state_d = ST_F0;
        if (d.valid) begin
          prev_d = d;
          if (is_last) begin
            any_d   = 1'b0;
            state_d = ST_LOAD;
          end else if (idx_q < lastb_q) begin
            // sum shifts up to the next box
            idx_d   = idx_q;
            tx_d    = '0;
            ty_d    = '0;
            sp_d    = idx_q + IDX_W'(1);
            raddr   = idx_q + IDX_W'(1);
            state_d = ST_S1;
          end
        end else if (idx_q < first_q) begin
          prev_d = d;
        end else if (idx_q < lastb_q) begin
          ov_d    = 1'b0;
          idx_d   = idx_q;
          sxq_d   = d.sx;
          syq_d   = d.sy;
          state_d = ST_MUL;
        end else begin
          ncx = sat_sum(prev_q.cx, PROD_W'(d.sx));
          ncy = sat_sum(prev_q.cy, PROD_W'(d.sy));
          ocx_d = ncx;  ocy_d = ncy;
          ow_d = prev_q.w;  oh_d = prev_q.h;  oc_d = prev_q.conf;  ol_d = prev_q.label;
          prev_d.cx = ncx;
          prev_d.cy = ncy;
          if (is_last) begin
            any_d   = 1'b0;
            state_d = ST_LOAD;
          end
        end
      end
      ST_S1: begin
        tx_d = tx_q + SUM_W'(d.sx);
        ty_d = ty_q + SUM_W'(d.sy);
        if (d.valid) begin
          dx_d    = DIFF_W'(d.cx) - DIFF_W'(prev_q.cx);
          dy_d    = DIFF_W'(d.cy) - DIFF_W'(prev_q.cy);
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_F0;
        end else begin
          sp_d  = sp_q + IDX_W'(1);
          raddr = sp_q + IDX_W'(1);
        end
      end
      ST_MUL: begin
        px_d    = PROD_W'(sxq_q) * PROD_W'(dx_q);
        py_d    = PROD_W'(syq_q) * PROD_W'(dy_q);
        state_d = ST_DST;
      end
      ST_DST: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (divx_done && divy_done) begin
          // a zero shift sum adds the shift as it is
          ncx = (tx_q == '0) ? sat_sum(prev_q.cx, PROD_W'(sxq_q)) : sat_sum(prev_q.cx, qx);
          ncy = (ty_q == '0) ? sat_sum(prev_q.cy, PROD_W'(syq_q)) : sat_sum(prev_q.cy, qy);
          ov_d = 1'b1;
          ocx_d = ncx;  ocy_d = ncy;
          ow_d = prev_q.w;  oh_d = prev_q.h;  oc_d = prev_q.conf;  ol_d = prev_q.label;
          ofill_d = 1'b1;  odrop_d = 1'b0;  olast_d = 1'b0;
          prev_d.cx = ncx;
          prev_d.cy = ncy;
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_F0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      any_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      any_q   <= any_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;  first_q <= first_d;  lastb_q <= lastb_d;
    idx_q <= idx_d;  sp_q <= sp_d;
    cur_q <= cur_d;  prev_q <= prev_d;
    tx_q <= tx_d;  ty_q <= ty_d;  dx_q <= dx_d;  dy_q <= dy_d;
    sxq_q <= sxq_d;  syq_q <= syq_d;  px_q <= px_d;  py_q <= py_d;
    ocx_q <= ocx_d;  ocy_q <= ocy_d;  ow_q <= ow_d;  oh_q <= oh_d;  oc_q <= oc_d;
    ol_q <= ol_d;  ofill_q <= ofill_d;  odrop_q <= odrop_d;  olast_q <= olast_d;
  end

  assign busy             = (state_q != ST_LOAD);
  assign out_valid_o      = ov_q;
  assign out_center_x_o   = ocx_q;
  assign out_center_y_o   = ocy_q;
  assign out_width_o      = ow_q;
  assign out_height_o     = oh_q;
  assign out_confidence_o = oc_q;
  assign out_label_o      = ol_q;
  assign was_filled_o     = ofill_q;
  assign track_dropped_o  = odrop_q;
  assign out_last_o       = olast_q;

endmodule

/* design/tbgf_checker.sv */
// ----------------------------------------------------------------------------
// Track box gap filler checker
// Port-level checks on the result strobe and the busy handshake.
// ----------------------------------------------------------------------------
`include "track_box_gap_filler_macros.svh"

module tbgf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                last_i,
  input logic                                out_valid_o,
  input logic                                was_filled_o,
  input logic                                track_dropped_o,
  input logic                                out_last_o
);

  // a dropped track is a single, final, unfilled result
  `TBGF_ASSERT_NOW(a_drop_last, out_valid_o && track_dropped_o, out_last_o && !was_filled_o)

  // the final transfer of a track finds the block free again
  `TBGF_ASSERT_NOW(a_last_frees, out_valid_o && out_last_o, !busy)

  // a result seen while free can only be the final one
  `TBGF_ASSERT_NOW(a_free_is_last, out_valid_o && !busy, out_last_o)

  // the entry with last starts the fill
  `TBGF_ASSERT_NEXT(a_last_busy, start && !busy && last_i, busy)

  // a plain entry gives no result
  `TBGF_ASSERT_NEXT(a_load_quiet, start && !busy && !last_i, !out_valid_o)

endmodule

bind track_box_gap_filler tbgf_checker u_tbgf_checker (.*);
